// ===== rtl/core/channel_buffer_status_table_assert.svh =====
// ----------------------------------------------------------------------------
// Channel buffer status table assertion macros
// Shared property wrappers for the checker. The design clock and reset are
// i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_BUFFER_STATUS_TABLE_ASSERT_SVH
`define CHANNEL_BUFFER_STATUS_TABLE_ASSERT_SVH

// Property checked only while the block is out of reset.
`define CBST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("cbst: property violated");

// Property that also covers the reset cycles.
`define CBST_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("cbst: reset property violated");

`endif

// ===== rtl/core/cbst_pkg.sv =====
// ----------------------------------------------------------------------------
// Channel buffer status table package
// Request and response types, codes, and the header size estimate.
// ----------------------------------------------------------------------------
package cbst_pkg;

    localparam int unsigned DEF_MAX_USERS    = 8;
    localparam int unsigned DEF_MAX_CHANNELS = 4;
    localparam int unsigned MAX_RESULTS      = 32;
    localparam int unsigned RES_CNT_W        = $clog2(MAX_RESULTS);
    localparam logic [23:0] BYTES_MAX        = 24'hFFFFFF;

    // Request type codes.
    typedef enum logic [1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_SENT    = 2'd1,
        REQ_REPORT  = 2'd2,
        REQ_UNUSED  = 2'd3
    } t_req_type;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_INACTIVE = 2'd2,
        ST_UNKNOWN  = 2'd3
    } t_status;

    // Input request payload.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  ue_slot;
        logic        um_mode;
        logic [7:0]  sdu_count;
        logic [4:0]  chan_id;
        logic [15:0] byte_count;
    } t_req;

    // Output response payload.
    typedef struct packed {
        logic [1:0]  status;
        logic        entry_valid;
        logic [2:0]  user_rank;
        logic [2:0]  user_slot_out;
        logic [2:0]  user_chan_count;
        logic [4:0]  chan_id_out;
        logic [23:0] queued_bytes;
        logic [8:0]  header_bytes;
        logic        last;
    } t_rsp;

    // One channel entry as held in the table memory.
    typedef struct packed {
        logic [4:0]  ident;
        logic [23:0] bytes;
        logic [8:0]  header;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_RESP,
        S_REP_USER,
        S_REP_DATA
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    cap_req;
        logic    user_clr;
        logic    user_inc;
        logic    chan_clr;
        logic    chan_inc;
        logic    rd_en;
        logic    wr_first;
        logic    wr_update;
        logic    wr_append;
        logic    set_status;
        t_status status;
        logic    rsp_load;
        logic    entry_load;
        logic    rep_start;
        logic    rank_inc;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] req_type;
        logic       slot_ok;
        logic       user_act;
        logic       id_match;
        logic       chan_more;
        logic       chan_room;
        logic       out_free;
        logic       any_active;
        logic       entry_last;
    } t_sts;

    // Header estimate: 2 for up to one SDU, else 2 + (3m)/2 + (m mod 2), m = n-1.
    function automatic logic [8:0] hdr_bytes(input logic [7:0] n);
        logic [7:0] m;
        logic [9:0] t;
        m = n - 8'd1;
        t = {2'b00, m} + {1'b0, m, 1'b0};
        if (n <= 8'd1) begin
            return 9'd2;
        end
        return t[9:1] + {8'd0, m[0]} + 9'd2;
    endfunction

endpackage

// ===== rtl/core/cbst_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cbst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/cbst_ctrl.sv =====
// ----------------------------------------------------------------------------
// Channel buffer status table controller
// Sequences request capture, channel search, updates and the report walk.
// ----------------------------------------------------------------------------
module cbst_ctrl
    import cbst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                case (i_sts.req_type)
                    REQ_ENQUEUE: begin
                        if (i_sts.slot_ok && i_sts.user_act) begin
                            n_state = S_SEARCH;
                        end else begin
                            n_state = S_RESP;
                        end
                    end
                    REQ_SENT: begin
                        if (i_sts.slot_ok && i_sts.user_act) begin
                            n_state = S_SEARCH;
                        end else begin
                            n_state = S_RESP;
                        end
                    end
                    REQ_REPORT: begin
                        if (i_sts.any_active) begin
                            n_state = S_REP_USER;
                        end else begin
                            n_state = S_RESP;
                        end
                    end
                    default: n_state = S_RESP;
                endcase
            end
            S_SEARCH: begin
                if (i_sts.id_match || !i_sts.chan_more) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_REP_USER: begin
                if (i_sts.user_act) begin
                    n_state = S_REP_DATA;
                end
            end
            S_REP_DATA: begin
                if (i_sts.out_free) begin
                    if (i_sts.entry_last) begin
                        n_state = S_IDLE;
                    end else if (!i_sts.chan_more) begin
                        n_state = S_REP_USER;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd        = '0;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.cap_req    = 1'b1;
                    o_cmd.set_status = 1'b1;
                end
            end
            S_CHECK: begin
                case (i_sts.req_type)
                    REQ_ENQUEUE: begin
                        if (!i_sts.slot_ok) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_INACTIVE;
                        end else if (!i_sts.user_act) begin
                            o_cmd.wr_first = 1'b1;
                        end else begin
                            o_cmd.chan_clr = 1'b1;
                            o_cmd.rd_en    = 1'b1;
                        end
                    end
                    REQ_SENT: begin
                        if (!i_sts.slot_ok || !i_sts.user_act) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_INACTIVE;
                        end else begin
                            o_cmd.chan_clr = 1'b1;
                            o_cmd.rd_en    = 1'b1;
                        end
                    end
                    REQ_REPORT: begin
                        if (i_sts.any_active) begin
                            o_cmd.rep_start = 1'b1;
                            o_cmd.user_clr  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_SEARCH: begin
                if (i_sts.id_match) begin
                    o_cmd.wr_update = 1'b1;
                end else if (i_sts.chan_more) begin
                    o_cmd.chan_inc = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                end else if (i_sts.req_type == REQ_ENQUEUE) begin
                    if (i_sts.chan_room) begin
                        o_cmd.wr_append = 1'b1;
                    end else begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_FULL;
                    end
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_UNKNOWN;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.rsp_load = 1'b1;
                end
            end
            S_REP_USER: begin
                if (i_sts.user_act) begin
                    o_cmd.chan_clr = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                end else begin
                    o_cmd.user_inc = 1'b1;
                end
            end
            S_REP_DATA: begin
                if (i_sts.out_free) begin
                    o_cmd.entry_load = 1'b1;
                    if (!i_sts.entry_last) begin
                        if (i_sts.chan_more) begin
                            o_cmd.chan_inc = 1'b1;
                            o_cmd.rd_en    = 1'b1;
                        end else begin
                            o_cmd.user_inc = 1'b1;
                            o_cmd.rank_inc = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

// ===== rtl/core/cbst_dpath.sv =====
// ----------------------------------------------------------------------------
// Channel buffer status table datapath
// Holds the per-user flags and counts, the channel table memory, the
// byte and header arithmetic and the response register.
// ----------------------------------------------------------------------------
module cbst_dpath
    import cbst_pkg::*;
#(
    parameter int unsigned MAX_USERS    = DEF_MAX_USERS,
    parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    input  logic i_rsp_ready,
    output logic o_rsp_valid,
    output t_rsp o_rsp
);

    localparam int unsigned UW    = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int unsigned CIW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned CW    = $clog2(MAX_CHANNELS + 1);
    localparam int unsigned DEPTH = MAX_USERS * MAX_CHANNELS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Request and walk registers.
    t_req                 r_req;
    t_status              r_status;
    t_status              n_status;
    logic [UW-1:0]        r_user;
    logic [UW-1:0]        n_user;
    logic [CIW-1:0]       r_chan;
    logic [CIW-1:0]       n_chan;
    logic [RES_CNT_W-1:0] r_k;
    logic [RES_CNT_W-1:0] n_k;
    logic [2:0]           r_rank;
    logic [2:0]           n_rank;

    // Per-user state.
    logic [MAX_USERS-1:0] r_active;
    logic [MAX_USERS-1:0] n_active;
    logic [CW-1:0]        r_used [MAX_USERS];
    logic [CW-1:0]        n_used [MAX_USERS];

    // Response register.
    logic r_out_valid;
    logic n_out_valid;
    t_rsp r_out;
    t_rsp n_out;

    // Memory ports.
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    t_entry             wr_entry;
    logic [ENTRY_W-1:0] rd_data;
    t_entry             rd_entry;

    // Derived values.
    logic [UW+2:0]   slot_wide;
    logic [UW+2:0]   user_wide;
    logic [CW+2:0]   cnt_wide;
    logic            user_act;
    logic [CW-1:0]   cur_used;
    logic            later_active;
    logic            chan_more;
    logic            out_free;
    logic            entry_last;
    logic [8:0]      hb_req;
    logic [8:0]      hb_sent;
    logic [24:0]     sum_bytes;
    logic [23:0]     upd_bytes;
    logic [CIW-1:0]  wr_chan;
    logic [CW-1:0]   used_inc;

    assign slot_wide = {{UW{1'b0}}, i_req.ue_slot};
    assign user_wide = {3'b000, r_user};
    assign cnt_wide  = {3'b000, cur_used};
    assign rd_entry  = t_entry'(rd_data);
    assign used_inc  = cur_used + 1'b1;

    // Select the flags and channel count of the current user.
    always_comb begin
        user_act     = 1'b0;
        cur_used     = '0;
        later_active = 1'b0;
        for (int j = 0; j < MAX_USERS; j++) begin
            if (UW'(j) == r_user) begin
                user_act = r_active[j];
                cur_used = r_used[j];
            end
            if (32'(j) > 32'(r_user) && r_active[j]) begin
                later_active = 1'b1;
            end
        end
    end

    assign chan_more  = (32'(r_chan) + 32'd1) < 32'(cur_used);
    assign out_free   = !r_out_valid || i_rsp_ready;
    assign entry_last = (r_k == RES_CNT_W'(MAX_RESULTS - 1)) || (!chan_more && !later_active);

    // Status toward the controller.
    always_comb begin
        o_sts            = '0;
        o_sts.req_type   = r_req.req_type;
        o_sts.slot_ok    = 32'(r_req.ue_slot) < MAX_USERS;
        o_sts.user_act   = user_act;
        o_sts.id_match   = (rd_entry.ident == r_req.chan_id);
        o_sts.chan_more  = chan_more;
        o_sts.chan_room  = 32'(cur_used) < MAX_CHANNELS;
        o_sts.out_free   = out_free;
        o_sts.any_active = |r_active;
        o_sts.entry_last = entry_last;
    end

    // Header estimates and saturating byte update.
    assign hb_sent = hdr_bytes(r_req.sdu_count);
    assign hb_req  = r_req.um_mode ? hb_sent : 9'd0;

    always_comb begin
        sum_bytes = {1'b0, rd_entry.bytes} + {9'd0, r_req.byte_count};
        if (r_req.req_type == REQ_ENQUEUE) begin
            upd_bytes = sum_bytes[24] ? BYTES_MAX : sum_bytes[23:0];
        end else if (rd_entry.bytes > {8'd0, r_req.byte_count}) begin
            upd_bytes = rd_entry.bytes - {8'd0, r_req.byte_count};
        end else begin
            upd_bytes = '0;
        end
    end

    // Channel index for the read and for the write.
    always_comb begin
        if (i_cmd.chan_clr) begin
            n_chan = '0;
        end else if (i_cmd.chan_inc) begin
            n_chan = r_chan + 1'b1;
        end else begin
            n_chan = r_chan;
        end
        if (i_cmd.wr_update) begin
            wr_chan = r_chan;
        end else if (i_cmd.wr_append) begin
            wr_chan = CIW'(cur_used);
        end else begin
            wr_chan = '0;
        end
    end

    assign rd_addr = AW'(32'(r_user) * MAX_CHANNELS + 32'(n_chan));
    assign wr_addr = AW'(32'(r_user) * MAX_CHANNELS + 32'(wr_chan));
    assign wr_en   = i_cmd.wr_first || i_cmd.wr_update || i_cmd.wr_append;

    // Entry written to the table.
    always_comb begin
        if (i_cmd.wr_update) begin
            wr_entry.ident  = rd_entry.ident;
            wr_entry.bytes  = upd_bytes;
            wr_entry.header = (r_req.req_type == REQ_ENQUEUE) ? hb_req : hb_sent;
        end else begin
            wr_entry.ident  = r_req.chan_id;
            wr_entry.bytes  = {8'd0, r_req.byte_count};
            wr_entry.header = hb_req;
        end
    end

    cbst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Next values of the walk registers and per-user state.
    always_comb begin
        n_status = i_cmd.set_status ? i_cmd.status : r_status;

        if (i_cmd.user_clr) begin
            n_user = '0;
        end else if (i_cmd.cap_req) begin
            n_user = slot_wide[UW-1:0];
        end else if (i_cmd.user_inc) begin
            n_user = r_user + 1'b1;
        end else begin
            n_user = r_user;
        end

        n_k    = r_k;
        n_rank = r_rank;
        if (i_cmd.rep_start) begin
            n_k    = '0;
            n_rank = '0;
        end else begin
            if (i_cmd.entry_load) begin
                n_k = r_k + 1'b1;
            end
            if (i_cmd.rank_inc) begin
                n_rank = r_rank + 3'd1;
            end
        end

        n_active = r_active;
        for (int j = 0; j < MAX_USERS; j++) begin
            n_used[j] = r_used[j];
            if (UW'(j) == r_user) begin
                if (i_cmd.wr_first) begin
                    n_active[j] = 1'b1;
                    n_used[j]   = CW'(1);
                end else if (i_cmd.wr_append) begin
                    n_used[j] = used_inc;
                end
            end
        end
    end

    // Response register next value.
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_rsp_ready;
        if (i_cmd.rsp_load) begin
            n_out        = '0;
            n_out.status = r_status;
            n_out.last   = 1'b1;
            n_out_valid  = 1'b1;
        end else if (i_cmd.entry_load) begin
            n_out.status          = ST_OK;
            n_out.entry_valid     = 1'b1;
            n_out.user_rank       = r_rank;
            n_out.user_slot_out   = user_wide[2:0];
            n_out.user_chan_count = cnt_wide[2:0];
            n_out.chan_id_out     = rd_entry.ident;
            n_out.queued_bytes    = rd_entry.bytes;
            n_out.header_bytes    = rd_entry.header;
            n_out.last            = entry_last;
            n_out_valid           = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_rank      <= '0;
            for (int j = 0; j < MAX_USERS; j++) begin
                r_used[j] <= '0;
            end
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
            r_rank      <= n_rank;
            for (int j = 0; j < MAX_USERS; j++) begin
                r_used[j] <= n_used[j];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_req) begin
            r_req <= i_req;
        end
        r_status <= n_status;
        r_user   <= n_user;
        r_chan   <= n_chan;
        r_out    <= n_out;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

// ===== rtl/core/channel_buffer_status_table.sv =====
// ----------------------------------------------------------------------------
// Channel buffer status table
// Keeps queued and header byte counts per user slot and logical channel.
// ----------------------------------------------------------------------------
// Requests arrive on i_req with i_req_valid/o_req_ready and responses leave
// on o_rsp with o_rsp_valid/i_rsp_ready. One request is worked on at a time;
// o_req_ready is high only while the controller is idle.
// Enqueue and sent requests give one response with last set. The channel
// search behind them does one table memory read per cycle.
// A report gives one response per held channel, users in slot order; the
// walk decodes the request, opens each active user and passes each inactive
// slot; at most 32 responses, the final one with last.
// A report with no active user gives one empty response.
// Responses sit in an output register; while the receiver stalls the walk
// pauses and the pending response holds. Reset clears all users, the
// response register and the controller; the table memory needs no clearing
// because only entries written since a user opened are ever read.
// ----------------------------------------------------------------------------
module channel_buffer_status_table
    import cbst_pkg::*;
#(
    parameter int unsigned MAX_USERS    = DEF_MAX_USERS,
    parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_cmd cmd;
    t_sts sts;

    // Request sequencing.
    cbst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Table storage and arithmetic.
    cbst_dpath #(
        .MAX_USERS    (MAX_USERS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== rtl/core/cbst_checker.sv =====
// ----------------------------------------------------------------------------
// Channel buffer status table checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "channel_buffer_status_table_assert.svh"

module cbst_checker
    import cbst_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input t_req i_req,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    // A stalled response holds its value.
    `CBST_ASSERT(a_rsp_hold, o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))

    // Reset empties the response register.
    `CBST_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_rsp_valid)

    // Only one request is in work at a time.
    `CBST_ASSERT(a_one_req, i_req_valid && o_req_ready |=> !o_req_ready)

    // Every response but the final one of a request is a report entry.
    `CBST_ASSERT(a_mid_entry, o_rsp_valid && !o_rsp.last |-> o_rsp.entry_valid && o_rsp.status == ST_OK)

    // A response without an entry is a single final one with empty fields.
    `CBST_ASSERT(a_empty_rsp, o_rsp_valid && !o_rsp.entry_valid |-> o_rsp.last && o_rsp.queued_bytes == 24'd0 && o_rsp.header_bytes == 9'd0 && o_rsp.chan_id_out == 5'd0)

endmodule

bind channel_buffer_status_table cbst_checker u_cbst_checker (.*);
